/* rtl/core/minibatch_optimizer_update_assert.svh */
// Assertion macros for the optimizer update engine.
`ifndef MINIBATCH_OPTIMIZER_UPDATE_ASSERT_SVH
`define MINIBATCH_OPTIMIZER_UPDATE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define MBOPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbopt: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define MBOPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbopt: next-cycle check failed");

`endif

/* rtl/core/mbopt_pkg.sv */
// Types, constants and helpers shared by the optimizer update engine.
package mbopt_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 24;
  localparam int DATA_W    = 32;
  localparam int COEF_W    = 24;
  localparam int BATCH_W   = 13;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 20;
  localparam int IDX_W     = 12;

  // Product path: 33 x 33 signed
  localparam int MOP_W  = DATA_W + 1;
  localparam int WIDE_W = 2 * MOP_W;

  // Divide / root unit
  localparam int MAG_W       = DATA_W + FRAC_BITS;
  localparam int DVD_W       = MAG_W + 1;
  localparam int DVS_W       = 29;
  localparam int REM_W       = DVS_W + 3;
  localparam int ROOT_W      = MAG_W / 2;
  localparam int DIV_STEPS   = MAG_W;
  localparam int SQRT_STEPS  = MAG_W / 2;
  localparam int CNT_W       = $clog2(DIV_STEPS + 1);

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [MOP_W-1:0]  mop_t;
  typedef logic [COEF_W:0]          coef_t;

  localparam coef_t ONE_Q    = coef_t'(1) << FRAC_BITS;
  localparam wide_t HALF_W   = wide_t'(1) << (FRAC_BITS - 1);
  localparam wide_t SAT_MAX  = wide_t'(64'sd2147483647);
  localparam wide_t SAT_MIN  = -wide_t'(64'sd2147483648);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_LR    = 3'd1,
    REG_WD    = 3'd2,
    REG_MOM   = 3'd3,
    REG_BETA1 = 3'd4,
    REG_BETA2 = 3'd5,
    REG_EPS   = 3'd6,
    REG_BATCH = 3'd7
  } cfg_reg_t;

  // Optimizer modes (the unused code runs as decoupled-decay Adam)
  typedef enum logic [1:0] {
    MODE_SGD   = 2'd0,
    MODE_ADAM  = 2'd1,
    MODE_ADAMW = 2'd2,
    MODE_SPARE = 2'd3
  } opt_mode_t;

  // Item opcodes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_GRAD = 1'b1
  } item_op_t;

  // Per-parameter storage row
  typedef struct packed {
    data_t w;
    data_t acc;
    data_t m1;
    data_t m2;
  } mem_entry_t;

  // Main sequencer
  typedef enum logic [4:0] {
    S_IDLE, S_ACC, S_GDIV0, S_GDIV, S_WD, S_WDR,
    S_SGD1, S_SGD2,
    S_ADM1, S_ADM2, S_ADM3, S_ADM4, S_ADM5, S_ADM6,
    S_PINIT, S_PM, S_PS, S_PB,
    S_CDIV0, S_CDIV, S_SQ0, S_SQ, S_RDIV0, S_RDIV,
    S_DECAY, S_WUPD, S_WFIN, S_DONE
  } opt_state_t;

  // Divide / root unit sequencer
  typedef enum logic [1:0] {
    DSQ_IDLE, DSQ_RUN, DSQ_FIN
  } dsq_state_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } dsq_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dsq_sts_t;

  // Clip to the 32-bit signed range
  function automatic data_t sat32(input wide_t x);
    data_t r;
    if (x > SAT_MAX)      r = data_t'(SAT_MAX);
    else if (x < SAT_MIN) r = data_t'(SAT_MIN);
    else                  r = data_t'(x);
    return r;
  endfunction

  function automatic logic clips(input wide_t x);
    return (x > SAT_MAX) || (x < SAT_MIN);
  endfunction

  // Coefficient register capped at one
  function automatic coef_t coef(input logic [COEF_W-1:0] r);
    coef_t c;
    c = {1'b0, r};
    return (c > ONE_Q) ? ONE_Q : c;
  endfunction

  function automatic mop_t mop_c(input coef_t c);
    return mop_t'($signed({1'b0, c}));
  endfunction

  function automatic mop_t mop_v(input data_t v);
    return mop_t'(v);
  endfunction

endpackage

/* rtl/core/mbopt_divsqrt.sv */
// Bit-serial signed divider and integer square root, one bit per cycle.
module mbopt_divsqrt (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mbopt_pkg::dsq_req_t                    req,
  input  logic signed [mbopt_pkg::DVD_W-1:0]     dividend,
  input  logic [mbopt_pkg::DVS_W-1:0]            divisor,
  output mbopt_pkg::dsq_sts_t                    sts,
  output logic signed [mbopt_pkg::DVD_W-1:0]     result
);

  mbopt_pkg::dsq_state_t state_r, state_nxt;

  logic [mbopt_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic [mbopt_pkg::MAG_W-1:0] q_r, q_nxt;
  logic [mbopt_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [mbopt_pkg::DVS_W-1:0] dvs_r;
  logic [mbopt_pkg::CNT_W-1:0] cnt_r;
  logic                        neg_r;
  logic                        sqrt_r;

  logic [mbopt_pkg::REM_W-1:0] rem_sh;
  logic [mbopt_pkg::REM_W-1:0] trial;
  logic [mbopt_pkg::DVD_W-1:0] dvd_abs;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mbopt_pkg::DSQ_IDLE: if (req.start) state_nxt = mbopt_pkg::DSQ_RUN;
      mbopt_pkg::DSQ_RUN:  if (cnt_r == mbopt_pkg::CNT_W'(1)) state_nxt = mbopt_pkg::DSQ_FIN;
      mbopt_pkg::DSQ_FIN:  state_nxt = mbopt_pkg::DSQ_IDLE;
      default:             state_nxt = mbopt_pkg::DSQ_IDLE;
    endcase
  end

  // Status outputs
  always_comb begin
    sts.busy = (state_r != mbopt_pkg::DSQ_IDLE);
    sts.done = (state_r == mbopt_pkg::DSQ_FIN);
    result   = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  end

  // One restoring step: one quotient bit or one root bit
  always_comb begin
    dvd_abs = dividend[mbopt_pkg::DVD_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
    if (sqrt_r) begin
      rem_sh  = {rem_r[mbopt_pkg::REM_W-3:0], mag_r[mbopt_pkg::MAG_W-1 -: 2]};
      trial   = {q_r[mbopt_pkg::REM_W-3:0], 2'b01};
      mag_nxt = mag_r << 2;
    end else begin
      rem_sh  = {rem_r[mbopt_pkg::REM_W-2:0], mag_r[mbopt_pkg::MAG_W-1]};
      trial   = mbopt_pkg::REM_W'(dvs_r);
      mag_nxt = mag_r << 1;
    end
    if (rem_sh >= trial) begin
      rem_nxt = rem_sh - trial;
      q_nxt   = {q_r[mbopt_pkg::MAG_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      q_nxt   = {q_r[mbopt_pkg::MAG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbopt_pkg::DSQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Operand and iteration registers
  always_ff @(posedge clk) begin
    if (state_r == mbopt_pkg::DSQ_IDLE && req.start) begin
      mag_r  <= dvd_abs[mbopt_pkg::MAG_W-1:0];
      neg_r  <= dividend[mbopt_pkg::DVD_W-1] & ~req.is_sqrt;
      sqrt_r <= req.is_sqrt;
      dvs_r  <= divisor;
      rem_r  <= '0;
      q_r    <= '0;
      cnt_r  <= req.is_sqrt ? mbopt_pkg::CNT_W'(mbopt_pkg::SQRT_STEPS)
                            : mbopt_pkg::CNT_W'(mbopt_pkg::DIV_STEPS);
    end else if (state_r == mbopt_pkg::DSQ_RUN) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - mbopt_pkg::CNT_W'(1);
    end
  end

endmodule

/* rtl/core/minibatch_optimizer_update.sv */
// Items are taken one at a time. A load or an out-of-range item goes straight to the result;
// a gradient is accumulated and, if an update is asked for, runs SGD, Adam or AdamW. Updates
// use a 56-step bit-serial divider (one division for SGD, four for Adam), a 28-step root and
// the square-and-multiply loop on the single 33x33 multiplier (a step count of zero counts as
// one). Reset (synchronous, active low) clears the sequencer and the output valid flag and
// loads register defaults; parameter memory holds garbage until loaded.
module minibatch_optimizer_update #(
  parameter int NUM_PARAMS = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [mbopt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbopt_pkg::CFG_W-1:0]           cfg_wdata,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic [mbopt_pkg::IDX_W-1:0]           in_param_index,
  input  logic                                  in_is_bias,
  input  logic signed [mbopt_pkg::DATA_W-1:0]   in_data_value,
  input  logic                                  in_apply_update,
  input  logic [mbopt_pkg::STEP_W-1:0]          in_step_count,
  // result items
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mbopt_pkg::IDX_W-1:0]           out_index,
  output logic signed [mbopt_pkg::DATA_W-1:0]   out_param_out,
  output logic                                  out_was_updated,
  output logic                                  out_saturated
);

  `include "minibatch_optimizer_update_assert.svh"

  localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

  // Configuration registers
  logic [1:0]                         mode_r;
  logic [mbopt_pkg::COEF_W-1:0]       lr_r, wd_cfg_r, mom_r, beta1_r, beta2_r, eps_r;
  logic [mbopt_pkg::BATCH_W-1:0]      batch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= mbopt_pkg::MODE_SGD;
      lr_r     <= 24'd167772;
      wd_cfg_r <= '0;
      mom_r    <= 24'd15099494;
      beta1_r  <= 24'd15099494;
      beta2_r  <= 24'd16760438;
      eps_r    <= 24'd1;
      batch_r  <= 13'd1;
    end else if (cfg_we) begin
      unique case (mbopt_pkg::cfg_reg_t'(cfg_index))
        mbopt_pkg::REG_MODE:  mode_r   <= cfg_wdata[1:0];
        mbopt_pkg::REG_LR:    lr_r     <= cfg_wdata;
        mbopt_pkg::REG_WD:    wd_cfg_r <= cfg_wdata;
        mbopt_pkg::REG_MOM:   mom_r    <= cfg_wdata;
        mbopt_pkg::REG_BETA1: beta1_r  <= cfg_wdata;
        mbopt_pkg::REG_BETA2: beta2_r  <= cfg_wdata;
        mbopt_pkg::REG_EPS:   eps_r    <= cfg_wdata;
        mbopt_pkg::REG_BATCH: batch_r  <= cfg_wdata[mbopt_pkg::BATCH_W-1:0];
        default:              mode_r   <= mode_r;
      endcase
    end
  end

  // Item and working registers
  mbopt_pkg::opt_state_t state_r, state_nxt;

  logic [mbopt_pkg::IDX_W-1:0]   idx_r;
  logic                          bias_r;
  mbopt_pkg::data_t              data_r;
  logic                          apply_r;
  logic [mbopt_pkg::STEP_W-1:0]  t_r;
  logic                          clip_r;
  logic                          upd_r;
  mbopt_pkg::data_t              res_w_r;

  mbopt_pkg::data_t              w_r, acc_r, m1_r, m2_r, g_r, t1_r, gg_r;
  mbopt_pkg::data_t              mh_r, vh_r, r_r;
  logic signed [mbopt_pkg::DATA_W:0] wd_r;
  mbopt_pkg::coef_t              pw_acc_r, pw_base_r;
  logic [mbopt_pkg::STEP_W-1:0]  pw_t_r;
  logic                          pw_sel_r;
  logic [mbopt_pkg::DVS_W-1:0]   den_r;

  // Output register
  logic                          out_valid_r;
  logic [mbopt_pkg::IDX_W-1:0]   out_index_r;
  mbopt_pkg::data_t              out_param_r;
  logic                          out_upd_r;
  logic                          out_sat_r;

  // Memory
  mbopt_pkg::mem_entry_t mem [NUM_PARAMS];
  mbopt_pkg::mem_entry_t mem_rd_r;
  mbopt_pkg::mem_entry_t mem_wdata;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;

  // Shared multiplier
  mbopt_pkg::mop_t  mul_a, mul_b;
  mbopt_pkg::wide_t prod_r;
  mbopt_pkg::wide_t mulq;

  // Divide / root unit
  mbopt_pkg::dsq_req_t                   dsq_req;
  mbopt_pkg::dsq_sts_t                   dsq_sts;
  logic signed [mbopt_pkg::DVD_W-1:0]    dsq_dvd;
  logic [mbopt_pkg::DVS_W-1:0]           dsq_dvs;
  logic signed [mbopt_pkg::DVD_W-1:0]    dsq_res;

  logic                   in_fire, in_range, out_load;
  logic                   is_sgd, is_adam_l2;
  mbopt_pkg::coef_t       c_val;
  logic [mbopt_pkg::BATCH_W-1:0] bs_val;
  mbopt_pkg::wide_t       acc_sum, sgd_sum, m1_sum, m2_sum, gd_sum, rd_sum, wn_sum;
  mbopt_pkg::wide_t       q_wide;
  logic [mbopt_pkg::DVS_W-1:0]   den_sum;

  assign in_fire    = in_valid && in_ready;
  assign in_range   = (32'(in_param_index) < NUM_PARAMS);
  assign is_sgd     = (mode_r == mbopt_pkg::MODE_SGD);
  assign is_adam_l2 = (mode_r == mbopt_pkg::MODE_ADAM);
  assign bs_val     = (batch_r == '0) ? mbopt_pkg::BATCH_W'(1) : batch_r;
  assign mulq       = (prod_r + mbopt_pkg::HALF_W) >>> mbopt_pkg::FRAC_BITS;
  assign q_wide     = mbopt_pkg::wide_t'(dsq_res);

  // Arithmetic around the shared units
  always_comb begin
    acc_sum = mbopt_pkg::wide_t'(mem_rd_r.acc) + mbopt_pkg::wide_t'(data_r);
    sgd_sum = mulq + mbopt_pkg::wide_t'(g_r) + mbopt_pkg::wide_t'(wd_r);
    gd_sum  = mbopt_pkg::wide_t'(g_r) + mbopt_pkg::wide_t'(wd_r);
    m1_sum  = mbopt_pkg::wide_t'(t1_r) + mulq;
    m2_sum  = mbopt_pkg::wide_t'(t1_r) + mulq;
    rd_sum  = mbopt_pkg::wide_t'(r_r) + mbopt_pkg::wide_t'(wd_r);
    wn_sum  = mbopt_pkg::wide_t'(w_r) - mulq;
    c_val   = mbopt_pkg::ONE_Q - pw_acc_r;
    if (c_val == '0) c_val = mbopt_pkg::coef_t'(1);
    den_sum = mbopt_pkg::DVS_W'(dsq_res[mbopt_pkg::ROOT_W-1:0])
            + mbopt_pkg::DVS_W'(mbopt_pkg::coef(eps_r));
    if (den_sum == '0) den_sum = mbopt_pkg::DVS_W'(1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mbopt_pkg::S_IDLE: begin
        if (in_fire) begin
          if (!in_range || in_op == mbopt_pkg::OP_LOAD) state_nxt = mbopt_pkg::S_DONE;
          else                                          state_nxt = mbopt_pkg::S_ACC;
        end
      end
      mbopt_pkg::S_ACC:   state_nxt = apply_r ? mbopt_pkg::S_GDIV0 : mbopt_pkg::S_DONE;
      mbopt_pkg::S_GDIV0: state_nxt = mbopt_pkg::S_GDIV;
      mbopt_pkg::S_GDIV:  if (dsq_sts.done) state_nxt = mbopt_pkg::S_WD;
      mbopt_pkg::S_WD:    state_nxt = mbopt_pkg::S_WDR;
      mbopt_pkg::S_WDR:   state_nxt = is_sgd ? mbopt_pkg::S_SGD1 : mbopt_pkg::S_ADM1;
      mbopt_pkg::S_SGD1:  state_nxt = mbopt_pkg::S_SGD2;
      mbopt_pkg::S_SGD2:  state_nxt = mbopt_pkg::S_WUPD;
      mbopt_pkg::S_ADM1:  state_nxt = mbopt_pkg::S_ADM2;
      mbopt_pkg::S_ADM2:  state_nxt = mbopt_pkg::S_ADM3;
      mbopt_pkg::S_ADM3:  state_nxt = mbopt_pkg::S_ADM4;
      mbopt_pkg::S_ADM4:  state_nxt = mbopt_pkg::S_ADM5;
      mbopt_pkg::S_ADM5:  state_nxt = mbopt_pkg::S_ADM6;
      mbopt_pkg::S_ADM6:  state_nxt = mbopt_pkg::S_PINIT;
      mbopt_pkg::S_PINIT: state_nxt = mbopt_pkg::S_PM;
      mbopt_pkg::S_PM:    state_nxt = mbopt_pkg::S_PS;
      mbopt_pkg::S_PS:    state_nxt = mbopt_pkg::S_PB;
      mbopt_pkg::S_PB: begin
        state_nxt = ((pw_t_r >> 1) == '0) ? mbopt_pkg::S_CDIV0 : mbopt_pkg::S_PM;
      end
      mbopt_pkg::S_CDIV0: state_nxt = mbopt_pkg::S_CDIV;
      mbopt_pkg::S_CDIV: begin
        if (dsq_sts.done) state_nxt = pw_sel_r ? mbopt_pkg::S_SQ0 : mbopt_pkg::S_PINIT;
      end
      mbopt_pkg::S_SQ0:   state_nxt = mbopt_pkg::S_SQ;
      mbopt_pkg::S_SQ:    if (dsq_sts.done) state_nxt = mbopt_pkg::S_RDIV0;
      mbopt_pkg::S_RDIV0: state_nxt = mbopt_pkg::S_RDIV;
      mbopt_pkg::S_RDIV: begin
        if (dsq_sts.done) state_nxt = is_adam_l2 ? mbopt_pkg::S_WUPD : mbopt_pkg::S_DECAY;
      end
      mbopt_pkg::S_DECAY: state_nxt = mbopt_pkg::S_WUPD;
      mbopt_pkg::S_WUPD:  state_nxt = mbopt_pkg::S_WFIN;
      mbopt_pkg::S_WFIN:  state_nxt = mbopt_pkg::S_DONE;
      mbopt_pkg::S_DONE:  if (out_load) state_nxt = mbopt_pkg::S_IDLE;
      default:            state_nxt = mbopt_pkg::S_IDLE;
    endcase
  end

  // Control outputs: handshake, memory port, multiplier and divider operands
  always_comb begin
    in_ready   = (state_r == mbopt_pkg::S_IDLE);
    out_load   = (state_r == mbopt_pkg::S_DONE) && (!out_valid_r || out_ready);
    mem_addr   = (state_r == mbopt_pkg::S_IDLE) ? AW'(in_param_index) : AW'(idx_r);
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = '{w: w_r, acc: '0, m1: m1_r, m2: m2_r};
    mul_a      = mbopt_pkg::mop_v(w_r);
    mul_b      = mbopt_pkg::mop_c(mbopt_pkg::coef(wd_cfg_r));
    dsq_req    = '{start: 1'b0, is_sqrt: 1'b0};
    dsq_dvd    = mbopt_pkg::DVD_W'(acc_r);
    dsq_dvs    = mbopt_pkg::DVS_W'(bs_val);
    unique case (state_r)
      mbopt_pkg::S_IDLE: begin
        if (in_fire && in_range) begin
          mem_we    = (in_op == mbopt_pkg::OP_LOAD);
          mem_re    = (in_op == mbopt_pkg::OP_GRAD);
          mem_wdata = '{w: in_data_value, acc: '0, m1: '0, m2: '0};
        end
      end
      mbopt_pkg::S_ACC: begin
        mem_we    = !apply_r;
        mem_wdata = '{w: mem_rd_r.w, acc: mbopt_pkg::sat32(acc_sum),
                      m1: mem_rd_r.m1, m2: mem_rd_r.m2};
      end
      mbopt_pkg::S_GDIV0: dsq_req.start = 1'b1;
      mbopt_pkg::S_SGD1: begin
        mul_a = mbopt_pkg::mop_c(mbopt_pkg::coef(mom_r));
        mul_b = mbopt_pkg::mop_v(m1_r);
      end
      mbopt_pkg::S_ADM1: begin
        mul_a = mbopt_pkg::mop_c(mbopt_pkg::coef(beta1_r));
        mul_b = mbopt_pkg::mop_v(m1_r);
      end
      mbopt_pkg::S_ADM2: begin
        mul_a = mbopt_pkg::mop_c(mbopt_pkg::ONE_Q - mbopt_pkg::coef(beta1_r));
        mul_b = mbopt_pkg::mop_v(g_r);
      end
      mbopt_pkg::S_ADM3: begin
        mul_a = mbopt_pkg::mop_v(g_r);
        mul_b = mbopt_pkg::mop_v(g_r);
      end
      mbopt_pkg::S_ADM4: begin
        mul_a = mbopt_pkg::mop_c(mbopt_pkg::coef(beta2_r));
        mul_b = mbopt_pkg::mop_v(m2_r);
      end
      mbopt_pkg::S_ADM5: begin
        mul_a = mbopt_pkg::mop_c(mbopt_pkg::ONE_Q - mbopt_pkg::coef(beta2_r));
        mul_b = mbopt_pkg::mop_v(gg_r);
      end
      mbopt_pkg::S_PM: begin
        mul_a = mbopt_pkg::mop_c(pw_acc_r);
        mul_b = mbopt_pkg::mop_c(pw_base_r);
      end
      mbopt_pkg::S_PS: begin
        mul_a = mbopt_pkg::mop_c(pw_base_r);
        mul_b = mbopt_pkg::mop_c(pw_base_r);
      end
      mbopt_pkg::S_CDIV0: begin
        dsq_req.start = 1'b1;
        dsq_dvd = mbopt_pkg::DVD_W'(pw_sel_r ? m2_r : m1_r) <<< mbopt_pkg::FRAC_BITS;
        dsq_dvs = mbopt_pkg::DVS_W'(c_val);
      end
      mbopt_pkg::S_SQ0: begin
        dsq_req = '{start: 1'b1, is_sqrt: 1'b1};
        dsq_dvd = mbopt_pkg::DVD_W'(vh_r) <<< mbopt_pkg::FRAC_BITS;
      end
      mbopt_pkg::S_RDIV0: begin
        dsq_req.start = 1'b1;
        dsq_dvd = mbopt_pkg::DVD_W'(mh_r) <<< mbopt_pkg::FRAC_BITS;
        dsq_dvs = den_r;
      end
      mbopt_pkg::S_WUPD: begin
        mul_a = mbopt_pkg::mop_c(mbopt_pkg::coef(lr_r));
        mul_b = mbopt_pkg::mop_v(r_r);
      end
      mbopt_pkg::S_WFIN: begin
        mem_we    = 1'b1;
        mem_wdata = '{w: mbopt_pkg::sat32(wn_sum), acc: '0, m1: m1_r, m2: m2_r};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbopt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Multiplier, registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Parameter memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_rd_r <= mem[mem_addr];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      mbopt_pkg::S_IDLE: begin
        if (in_fire) begin
          idx_r   <= in_param_index;
          bias_r  <= in_is_bias;
          data_r  <= in_data_value;
          apply_r <= in_apply_update & in_range;
          t_r     <= in_step_count;
          clip_r  <= 1'b0;
          upd_r   <= 1'b0;
          res_w_r <= in_range ? in_data_value : '0;
        end
      end
      mbopt_pkg::S_ACC: begin
        w_r     <= mem_rd_r.w;
        m1_r    <= mem_rd_r.m1;
        m2_r    <= mem_rd_r.m2;
        acc_r   <= mbopt_pkg::sat32(acc_sum);
        clip_r  <= clip_r | mbopt_pkg::clips(acc_sum);
        res_w_r <= mem_rd_r.w;
      end
      mbopt_pkg::S_GDIV: if (dsq_sts.done) g_r <= dsq_res[mbopt_pkg::DATA_W-1:0];
      mbopt_pkg::S_WDR: begin
        wd_r <= bias_r ? '0 : mulq[mbopt_pkg::DATA_W:0];
      end
      mbopt_pkg::S_SGD2: begin
        m1_r   <= mbopt_pkg::sat32(sgd_sum);
        r_r    <= mbopt_pkg::sat32(sgd_sum);
        clip_r <= clip_r | mbopt_pkg::clips(sgd_sum);
      end
      mbopt_pkg::S_ADM1: begin
        if (is_adam_l2) begin
          g_r    <= mbopt_pkg::sat32(gd_sum);
          clip_r <= clip_r | mbopt_pkg::clips(gd_sum);
        end
      end
      mbopt_pkg::S_ADM2: t1_r <= mbopt_pkg::data_t'(mulq);
      mbopt_pkg::S_ADM3: begin
        m1_r   <= mbopt_pkg::sat32(m1_sum);
        clip_r <= clip_r | mbopt_pkg::clips(m1_sum);
      end
      mbopt_pkg::S_ADM4: begin
        gg_r   <= mbopt_pkg::sat32(mulq);
        clip_r <= clip_r | mbopt_pkg::clips(mulq);
      end
      mbopt_pkg::S_ADM5: t1_r <= mbopt_pkg::data_t'(mulq);
      mbopt_pkg::S_ADM6: begin
        m2_r     <= mbopt_pkg::sat32(m2_sum);
        clip_r   <= clip_r | mbopt_pkg::clips(m2_sum);
        pw_sel_r <= 1'b0;
      end
      mbopt_pkg::S_PINIT: begin
        pw_acc_r  <= mbopt_pkg::ONE_Q;
        pw_base_r <= mbopt_pkg::coef(pw_sel_r ? beta2_r : beta1_r);
        pw_t_r    <= (t_r == '0) ? mbopt_pkg::STEP_W'(1) : t_r;
      end
      mbopt_pkg::S_PS: begin
        if (pw_t_r[0]) pw_acc_r <= mulq[mbopt_pkg::COEF_W:0];
      end
      mbopt_pkg::S_PB: begin
        pw_base_r <= mulq[mbopt_pkg::COEF_W:0];
        pw_t_r    <= pw_t_r >> 1;
      end
      mbopt_pkg::S_CDIV: begin
        if (dsq_sts.done) begin
          clip_r <= clip_r | mbopt_pkg::clips(q_wide);
          if (!pw_sel_r) begin
            mh_r     <= mbopt_pkg::sat32(q_wide);
            pw_sel_r <= 1'b1;
          end else begin
            // negative second moment corrects to zero
            vh_r <= (q_wide < 0) ? '0 : mbopt_pkg::sat32(q_wide);
          end
        end
      end
      mbopt_pkg::S_SQ: if (dsq_sts.done) den_r <= den_sum;
      mbopt_pkg::S_RDIV: begin
        if (dsq_sts.done) begin
          r_r    <= mbopt_pkg::sat32(q_wide);
          clip_r <= clip_r | mbopt_pkg::clips(q_wide);
        end
      end
      mbopt_pkg::S_DECAY: begin
        r_r    <= mbopt_pkg::sat32(rd_sum);
        clip_r <= clip_r | mbopt_pkg::clips(rd_sum);
      end
      mbopt_pkg::S_WFIN: begin
        res_w_r <= mbopt_pkg::sat32(wn_sum);
        clip_r  <= clip_r | mbopt_pkg::clips(wn_sum);
        upd_r   <= 1'b1;
      end
      default: begin
        res_w_r <= res_w_r;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= idx_r;
      out_param_r <= res_w_r;
      out_upd_r   <= upd_r;
      out_sat_r   <= clip_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_index       = out_index_r;
  assign out_param_out   = out_param_r;
  assign out_was_updated = out_upd_r;
  assign out_saturated   = out_sat_r;

  mbopt_divsqrt u_divsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dsq_req),
    .dividend (dsq_dvd),
    .divisor  (dsq_dvs),
    .sts      (dsq_sts),
    .result   (dsq_res)
  );

  // Checks
  `MBOPT_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
  `MBOPT_ASSERT_NOW(a_start_when_free, dsq_req.start, !dsq_sts.busy)
  `MBOPT_ASSERT_NOW(a_mem_single_access, mem_we, !mem_re)
  `MBOPT_ASSERT_NEXT(a_result_after_load, out_load, out_valid)

endmodule

/* dv/mbopt_result_checker.sv */
// Result checker for the optimizer update engine: predicts every result and compares it.
`timescale 1ns / 1ps

module mbopt_result_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mbopt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbopt_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 in_op,
  input  logic [mbopt_pkg::IDX_W-1:0]          in_param_index,
  input  logic                                 in_is_bias,
  input  logic signed [mbopt_pkg::DATA_W-1:0]  in_data_value,
  input  logic                                 in_apply_update,
  input  logic [mbopt_pkg::STEP_W-1:0]         in_step_count,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [mbopt_pkg::IDX_W-1:0]          out_index,
  input  logic signed [mbopt_pkg::DATA_W-1:0]  out_param_out,
  input  logic                                 out_was_updated,
  input  logic                                 out_saturated,
  output int                                   mismatches,
  output int                                   pending
);

  localparam longint UNIT = longint'(1) << mbopt_pkg::FRAC_BITS;
  localparam longint HALF = longint'(1) << (mbopt_pkg::FRAC_BITS - 1);
  localparam longint TOP  = 64'sd2147483647;
  localparam longint BOT  = -64'sd2147483648;

  typedef struct {
    logic [mbopt_pkg::IDX_W-1:0]         idx;
    logic signed [mbopt_pkg::DATA_W-1:0] w;
    bit                                  upd;
    bit                                  sat;
  } param_result_t;

  // Shadow of the register file
  mbopt_pkg::opt_mode_t          mode_q;
  logic [mbopt_pkg::COEF_W-1:0]  lr_q, wd_q, mom_q, b1_q, b2_q, eps_q;
  logic [mbopt_pkg::BATCH_W-1:0] batch_q;

  // Shadow of the parameter memory
  logic signed [mbopt_pkg::DATA_W-1:0] w_mem  [4096];
  logic signed [mbopt_pkg::DATA_W-1:0] acc_mem[4096];
  logic signed [mbopt_pkg::DATA_W-1:0] m1_mem [4096];
  logic signed [mbopt_pkg::DATA_W-1:0] m2_mem [4096];

  param_result_t expected_params[$];
  bit clip_hit;

  function automatic longint clip32(longint x);
    if (x > TOP) begin
      clip_hit = 1'b1;
      return TOP;
    end
    if (x < BOT) begin
      clip_hit = 1'b1;
      return BOT;
    end
    return x;
  endfunction

  // Rounded fixed-point product, floor after adding one half
  function automatic longint qmul(longint a, longint b);
    return (a * b + HALF) >>> mbopt_pkg::FRAC_BITS;
  endfunction

  function automatic longint cap_one(logic [mbopt_pkg::COEF_W-1:0] r);
    longint c;
    c = longint'(r);
    return (c > UNIT) ? UNIT : c;
  endfunction

  // beta^t by square-and-multiply, t of zero counts as one
  function automatic longint beta_pow(longint base, logic [mbopt_pkg::STEP_W-1:0] t);
    longint acc;
    acc = UNIT;
    if (t == 0) t = 1;
    while (t != 0) begin
      if (t[0]) acc = qmul(acc, base);
      base = qmul(base, base);
      t = t >> 1;
    end
    return acc;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Runs one optimizer update on entry i
  function automatic void apply_step(int i, bit bias, logic [mbopt_pkg::STEP_W-1:0] t);
    longint w, bs, g, lr, wdt, b1, b2, c1, c2, m1, m2, mh, vh, den, r;
    w   = w_mem[i];
    bs  = (batch_q == 0) ? 1 : longint'(batch_q);
    g   = longint'(acc_mem[i]) / bs;
    lr  = cap_one(lr_q);
    wdt = bias ? 0 : qmul(cap_one(wd_q), w);
    if (mode_q == mbopt_pkg::MODE_SGD) begin
      m1 = clip32(qmul(cap_one(mom_q), longint'(m1_mem[i])) + g + wdt);
      m1_mem[i] = m1[31:0];
      w = clip32(w - qmul(lr, m1));
    end else begin
      b1 = cap_one(b1_q);
      b2 = cap_one(b2_q);
      if (mode_q == mbopt_pkg::MODE_ADAM) g = clip32(g + wdt);
      m1 = clip32(qmul(b1, longint'(m1_mem[i])) + qmul(UNIT - b1, g));
      m2 = clip32(qmul(b2, longint'(m2_mem[i])) + qmul(UNIT - b2, clip32(qmul(g, g))));
      m1_mem[i] = m1[31:0];
      m2_mem[i] = m2[31:0];
      c1 = UNIT - beta_pow(b1, t);
      c2 = UNIT - beta_pow(b2, t);
      if (c1 <= 0) c1 = 1;
      if (c2 <= 0) c2 = 1;
      mh = clip32(m1 * UNIT / c1);
      vh = clip32(m2 * UNIT / c2);
      if (vh < 0) vh = 0;
      den = longint'(int_sqrt(longint'(vh) * UNIT)) + cap_one(eps_q);
      if (den <= 0) den = 1;
      r = clip32(mh * UNIT / den);
      if (mode_q != mbopt_pkg::MODE_ADAM) r = clip32(r + wdt);
      w = clip32(w - qmul(lr, r));
    end
    w_mem[i]   = w[31:0];
    acc_mem[i] = '0;
  endfunction

  function automatic param_result_t predict_param(logic op, logic [mbopt_pkg::IDX_W-1:0] idx,
                                                  bit bias,
                                                  logic signed [mbopt_pkg::DATA_W-1:0] data,
                                                  bit apply,
                                                  logic [mbopt_pkg::STEP_W-1:0] t);
    param_result_t res;
    longint a;
    clip_hit = 1'b0;
    res.upd  = 1'b0;
    if (op == mbopt_pkg::OP_LOAD) begin
      w_mem[idx]   = data;
      acc_mem[idx] = '0;
      m1_mem[idx]  = '0;
      m2_mem[idx]  = '0;
    end else begin
      a = clip32(longint'(acc_mem[idx]) + longint'(data));
      acc_mem[idx] = a[31:0];
      if (apply) begin
        apply_step(idx, bias, t);
        res.upd = 1'b1;
      end
    end
    res.idx = idx;
    res.w   = w_mem[idx];
    res.sat = clip_hit;
    return res;
  endfunction

  always @(posedge clk) begin
    param_result_t exp_r;
    if (!rst_n) begin
      mode_q  <= mbopt_pkg::MODE_SGD;
      lr_q    <= 24'd167772;
      wd_q    <= 24'd0;
      mom_q   <= 24'd15099494;
      b1_q    <= 24'd15099494;
      b2_q    <= 24'd16760438;
      eps_q   <= 24'd1;
      batch_q <= 13'd1;
      expected_params.delete();
    end else begin
      // Register writes
      if (cfg_we) begin
        case (mbopt_pkg::cfg_reg_t'(cfg_index))
          mbopt_pkg::REG_MODE:  mode_q  <= mbopt_pkg::opt_mode_t'(cfg_wdata[1:0]);
          mbopt_pkg::REG_LR:    lr_q    <= cfg_wdata;
          mbopt_pkg::REG_WD:    wd_q    <= cfg_wdata;
          mbopt_pkg::REG_MOM:   mom_q   <= cfg_wdata;
          mbopt_pkg::REG_BETA1: b1_q    <= cfg_wdata;
          mbopt_pkg::REG_BETA2: b2_q    <= cfg_wdata;
          mbopt_pkg::REG_EPS:   eps_q   <= cfg_wdata;
          mbopt_pkg::REG_BATCH: batch_q <= cfg_wdata[mbopt_pkg::BATCH_W-1:0];
          default: ;
        endcase
      end
      // Accepted input item
      if (in_valid && in_ready)
        expected_params.push_back(predict_param(in_op, in_param_index, in_is_bias,
                                                in_data_value, in_apply_update,
                                                in_step_count));
      // Accepted result item
      if (out_valid && out_ready) begin
        if (expected_params.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("%0t: unexpected result idx=%0d w=%0d", $realtime, out_index,
                     out_param_out);
        end else begin
          exp_r = expected_params.pop_front();
          if (exp_r.idx !== out_index || exp_r.w !== out_param_out ||
              exp_r.upd !== out_was_updated || exp_r.sat !== out_saturated) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("%0t: exp idx=%0d w=%0d upd=%0b sat=%0b, got idx=%0d w=%0d upd=%0b sat=%0b",
                       $realtime, exp_r.idx, exp_r.w, exp_r.upd, exp_r.sat,
                       out_index, out_param_out, out_was_updated, out_saturated);
          end
        end
      end
    end
    pending <= expected_params.size();
  end

endmodule

/* dv/tb_minibatch_optimizer_update.sv */
// Stimulus and verdict for the optimizer update engine.
`timescale 1ns / 1ps

module tb_minibatch_optimizer_update;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [mbopt_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [mbopt_pkg::CFG_W-1:0]         cfg_wdata;
  logic                                in_valid, in_ready;
  logic                                in_op;
  logic [mbopt_pkg::IDX_W-1:0]         in_param_index;
  logic                                in_is_bias;
  logic signed [mbopt_pkg::DATA_W-1:0] in_data_value;
  logic                                in_apply_update;
  logic [mbopt_pkg::STEP_W-1:0]        in_step_count;
  logic                                out_valid, out_ready;
  logic [mbopt_pkg::IDX_W-1:0]         out_index;
  logic signed [mbopt_pkg::DATA_W-1:0] out_param_out;
  logic                                out_was_updated, out_saturated;
  int                                  mismatches, pending;

  bit          loaded[4096];
  int          hot_idx[16];
  int          burst_left;
  int          stall_ctr;
  logic [1:0]  stall_mode;

  minibatch_optimizer_update dut (.*);
  mbopt_result_checker checker_i (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver stalls: ready held high, random, or high one time in four, redrawn on a free-running counter
  always @(posedge clk) begin
    stall_ctr <= stall_ctr + 1;
    if (stall_ctr[5:0] == 0) stall_mode <= 2'($urandom_range(0, 2));
    case (stall_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= 1'($urandom);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic write_reg(mbopt_pkg::cfg_reg_t r, logic [mbopt_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(mbopt_pkg::item_op_t op, int idx, bit bias, logic [31:0] data,
                           bit apply, logic [mbopt_pkg::STEP_W-1:0] t);
    in_valid        <= 1'b1;
    in_op           <= op;
    in_param_index  <= mbopt_pkg::IDX_W'(idx);
    in_is_bias      <= bias;
    in_data_value   <= data;
    in_apply_update <= apply;
    in_step_count   <= t;
    if (op == mbopt_pkg::OP_LOAD) loaded[idx] = 1'b1;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Sender bursts with random gaps in between
  task automatic pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    wait (pending == 0);
    repeat (20) @(posedge clk);
    wait (pending == 0);
    repeat (500) @(posedge clk);
  endtask

  task automatic program_phase(int p);
    mbopt_pkg::opt_mode_t m;
    m = (p == 3) ? mbopt_pkg::MODE_SPARE : mbopt_pkg::opt_mode_t'(p % 3);
    write_reg(mbopt_pkg::REG_MODE, mbopt_pkg::CFG_W'(m));
    if (p == 1) begin
      // every coefficient at its top value, batch size 4096
      write_reg(mbopt_pkg::REG_LR, 24'hFFFFFF);
      write_reg(mbopt_pkg::REG_WD, 24'hFFFFFF);
      write_reg(mbopt_pkg::REG_MOM, 24'hFFFFFF);
      write_reg(mbopt_pkg::REG_BETA1, 24'hFFFFFF);
      write_reg(mbopt_pkg::REG_BETA2, 24'hFFFFFF);
      write_reg(mbopt_pkg::REG_EPS, 24'hFFFFFF);
      write_reg(mbopt_pkg::REG_BATCH, 24'd4096);
    end else if (p == 2) begin
      // rates and coefficients at zero, eps and batch size at one
      write_reg(mbopt_pkg::REG_LR, 24'd0);
      write_reg(mbopt_pkg::REG_WD, 24'd0);
      write_reg(mbopt_pkg::REG_MOM, 24'd0);
      write_reg(mbopt_pkg::REG_BETA1, 24'd0);
      write_reg(mbopt_pkg::REG_BETA2, 24'd0);
      write_reg(mbopt_pkg::REG_EPS, 24'd1);
      write_reg(mbopt_pkg::REG_BATCH, 24'd1);
    end else begin
      write_reg(mbopt_pkg::REG_LR, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(mbopt_pkg::REG_WD, ($urandom_range(0, 1) != 0) ? 24'($urandom)
                                                               : 24'($urandom_range(0, 1 << 18)));
      write_reg(mbopt_pkg::REG_MOM, 24'($urandom));
      write_reg(mbopt_pkg::REG_BETA1, 24'($urandom_range(24'hC00000, 24'hFFFFFF)));
      write_reg(mbopt_pkg::REG_BETA2, ($urandom_range(0, 1) != 0) ? 24'($urandom) : 24'hFFF000);
      write_reg(mbopt_pkg::REG_EPS, 24'($urandom_range(1, 24'hFFFFFF)));
      write_reg(mbopt_pkg::REG_BATCH, ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 4096))
                                                                  : 24'($urandom_range(1, 8)));
    end
  endtask

  // Corner items: extremes, accumulator clip, step count zero and maximum, load with update
  task automatic run_corners();
    send_item(mbopt_pkg::OP_LOAD, 0, 1'b0, 32'h7FFFFFFF, 1'b1, 20'd5);
    send_item(mbopt_pkg::OP_LOAD, 4095, 1'b1, 32'h80000000, 1'b0, 20'd0);
    send_item(mbopt_pkg::OP_GRAD, 0, 1'b0, 32'h7FFFFFFF, 1'b0, 20'd1);
    send_item(mbopt_pkg::OP_GRAD, 0, 1'b0, 32'h7FFFFFFF, 1'b1, 20'd0);
    send_item(mbopt_pkg::OP_GRAD, 4095, 1'b1, 32'h80000000, 1'b1, 20'd1);
    send_item(mbopt_pkg::OP_LOAD, 12'hA5A, 1'b0, 32'h01000000, 1'b0, 20'hFFFFF);
    send_item(mbopt_pkg::OP_GRAD, 12'hA5A, 1'b0, 32'h00400000, 1'b1, 20'hFFFFF);
    send_item(mbopt_pkg::OP_GRAD, 12'hA5A, 1'b1, 32'hFFC00000, 1'b1, 20'd2);
  endtask

  task automatic run_random(int n);
    int idx;
    int pick;
    logic [31:0] data;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      idx  = (pick < 10) ? $urandom_range(0, 4095) : hot_idx[$urandom_range(0, 15)];
      case ($urandom_range(0, 9))
        0, 1:    data = $urandom;
        2:       data = ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
        default: data = 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      endcase
      if (pick < 20 || !loaded[idx])
        send_item(mbopt_pkg::OP_LOAD, idx, 1'($urandom), data, 1'($urandom), 20'($urandom));
      else
        send_item(mbopt_pkg::OP_GRAD, idx, 1'($urandom), data, ($urandom_range(0, 9) < 3),
                  ($urandom_range(0, 4) == 0) ? 20'($urandom) : 20'($urandom_range(0, 64)));
      if (k != n - 1) pace();
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= mbopt_pkg::REG_MODE;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_op           <= mbopt_pkg::OP_LOAD;
    in_param_index  <= '0;
    in_is_bias      <= 1'b0;
    in_data_value   <= '0;
    in_apply_update <= 1'b0;
    in_step_count   <= '0;
    burst_left      = 0;
    hot_idx[0] = 0;
    hot_idx[1] = 4095;
    for (int i = 2; i < 16; i++) hot_idx[i] = $urandom_range(0, 4095);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 8; p++) begin
      program_phase(p);
      @(posedge clk);
      if (p < 3) begin
        run_corners();
        in_valid <= 1'b0;
        @(posedge clk);
      end
      run_random(105);
      drain();
    end

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hang guard
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
